// ===== rtl/sdue_pkg.sv =====
// Shared types and constants for the SSE diagonal update engine.
// No dependencies.
`default_nettype none
package sdue_pkg;
    localparam int MAX_SITES = 256;
    localparam int MAX_LEN   = 4096;

    localparam logic [1:0] OP_PROCESS = 2'd0;
    localparam logic [1:0] OP_SPIN    = 2'd1;
    localparam logic [1:0] OP_COUNT   = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [1:0] REG_LX     = 2'd0;
    localparam logic [1:0] REG_LY     = 2'd1;
    localparam logic [1:0] REG_LEN    = 2'd2;
    localparam logic [1:0] REG_WEIGHT = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_FLIP   = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [1:0]         kind;
        logic signed [10:0] entry_code;
        logic [8:0]         bond;
        logic [15:0]        random_fraction;
        logic [7:0]         site_index;
        logic               spin_value;
        logic [12:0]        count_value;
    } item_t;
endpackage
`default_nettype wire

// ===== rtl/sdue_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sdue_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]              rdata_a,
    output logic [WIDTH-1:0]              rdata_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end
endmodule
`default_nettype wire

// ===== rtl/sdue_front.sv =====
// Front end: accepts input words, classifies them, queues them (2 deep).
// Depends on sdue_pkg.
`default_nettype none
module sdue_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire sdue_pkg::item_t   in_item,
    output logic                   q_valid,
    input  wire logic              q_pop,
    output sdue_pkg::item_t        q_item
);
    sdue_pkg::item_t  slot_reg [2];
    logic [1:0]       cnt_reg, cnt_next;
    logic             rd_reg, wr_reg;
    logic             push;
    sdue_pkg::item_t  cls;

    always_comb
    begin
        cls = in_item;
        cls.kind = sdue_pkg::KIND_NONE;
        if (in_item.op == sdue_pkg::OP_PROCESS)
        begin
            if (in_item.entry_code == -11'sd1)
            begin
                cls.kind = sdue_pkg::KIND_INSERT;
            end
            else if (!in_item.entry_code[10])
            begin
                cls.kind = in_item.entry_code[0] ? sdue_pkg::KIND_FLIP
                                                 : sdue_pkg::KIND_REMOVE;
                cls.bond = in_item.entry_code[9:1];
            end
        end
    end

    assign in_stall = cnt_reg[1];
    assign push     = in_valid && !in_stall;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_item   = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (q_pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= cls;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/sdue_back.sv =====
// Back end: bond mapping, spin store, acceptance tests, result register.
// Depends on sdue_pkg and sdue_ram.
`default_nettype none
module sdue_back #(
    parameter int MAX_SITES = sdue_pkg::MAX_SITES,
    parameter int MAX_LEN   = sdue_pkg::MAX_LEN
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_pop,
    input  wire sdue_pkg::item_t q_item,
    input  wire logic [4:0]      lattice_x,
    input  wire logic [4:0]      lattice_y,
    input  wire logic [12:0]     string_length,
    input  wire logic [23:0]     insert_weight,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic signed [10:0]   new_entry_code,
    output logic [12:0]          operator_count
);
    localparam int SW = $clog2(MAX_SITES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_DEC  = 3'd5;
    localparam logic [2:0] ST_WR2  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0]        st_reg, st_next;
    sdue_pkg::item_t   it_reg;
    logic [12:0]       n_reg;
    logic [4:0]        lx_reg, ly_reg;
    logic [12:0]       m_reg;
    logic [7:0]        quo_reg, rem_reg;
    logic [3:0]        dcnt_reg;
    logic [SW-1:0]     s0_reg, s1_reg;
    logic              bok_reg;
    logic [39:0]       prod_reg;
    logic [39:0]       lhs_reg;
    logic              ins_reg, rem_ok_reg;
    logic signed [10:0] res_code_reg;
    logic signed [10:0] out_code_reg;
    logic [12:0]       out_count_reg;
    logic              ov_reg;

    logic              we;
    logic [SW-1:0]     waddr;
    logic              wdata;
    logic              rd_a, rd_b;

    logic [4:0]  lx_c, ly_c;
    logic [12:0] m_c;
    logic [7:0]  bond_cell;
    logic [8:0]  rem_try;
    logic [9:0]  nb;
    logic [4:0]  x1, y1;
    logic [9:0]  a0, a1;

    always_comb
    begin
        lx_c = (lattice_x < 5'd2) ? 5'd2 : (lattice_x > 5'd16) ? 5'd16 : lattice_x;
        ly_c = (lattice_y < 5'd2) ? 5'd2 : (lattice_y > 5'd16) ? 5'd16 : lattice_y;
        m_c  = (32'(string_length) > MAX_LEN) ? 13'(MAX_LEN) : string_length;
        bond_cell = it_reg.bond[8:1];
        rem_try = {rem_reg, bond_cell[7 - 3'(dcnt_reg[2:0])]};
        nb = 10'(2 * lx_reg * ly_reg);
        x1 = (5'(quo_reg) + 5'd1 == lx_reg) ? 5'd0 : 5'(quo_reg) + 5'd1;
        y1 = (5'(rem_reg) + 5'd1 == ly_reg) ? 5'd0 : 5'(rem_reg) + 5'd1;
        a0 = 10'(rem_reg) * 10'(lx_reg) + 10'(quo_reg);
        a1 = it_reg.bond[0] ? 10'(y1) * 10'(lx_reg) + 10'(quo_reg)
                            : 10'(rem_reg) * 10'(lx_reg) + 10'(x1);
    end

    sdue_ram #(.WIDTH(1), .DEPTH(MAX_SITES)) u_spin (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (s0_reg),
        .raddr_b (s1_reg),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    // flips write s0 in DEC and s1 in WR2; spin writes go in DEC
    always_comb
    begin
        we    = 1'b0;
        waddr = s0_reg;
        wdata = !rd_a;
        if (st_reg == ST_DEC)
        begin
            if (it_reg.op == sdue_pkg::OP_SPIN)
            begin
                we    = 1'b1;
                waddr = SW'(it_reg.site_index);
                wdata = it_reg.spin_value;
            end
            else if (it_reg.kind == sdue_pkg::KIND_FLIP && bok_reg && s0_reg != s1_reg)
            begin
                we = 1'b1;
            end
        end
        else if (st_reg == ST_WR2)
        begin
            we    = 1'b1;
            waddr = s1_reg;
            wdata = !rd_b;
        end
    end

    assign q_pop          = (st_reg == ST_IDLE) && q_valid;
    assign out_valid      = ov_reg;
    assign new_entry_code = out_code_reg;
    assign operator_count = out_count_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: if (q_valid) st_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == 4'd7) st_next = ST_ADDR;
            ST_ADDR: st_next = ST_READ;
            ST_READ: st_next = ST_MUL;
            ST_MUL:  st_next = ST_DEC;
            ST_DEC:  st_next = (it_reg.kind == sdue_pkg::KIND_FLIP && bok_reg
                                && s0_reg != s1_reg
                                && it_reg.op == sdue_pkg::OP_PROCESS) ? ST_WR2 : ST_OUT;
            ST_WR2:  st_next = ST_OUT;
            ST_OUT:  if (!ov_reg || !out_stall) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            n_reg    <= 13'd0;
            ov_reg   <= 1'b0;
            dcnt_reg <= 4'd0;
        end
        else
        begin
            st_reg <= st_next;
            // output word loads when the previous one is gone or leaving
            if (st_reg == ST_OUT && (!ov_reg || !out_stall))
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: dcnt_reg <= 4'd0;
                ST_DIV:  dcnt_reg <= dcnt_reg + 4'd1;
                ST_DEC:
                begin
                    if (it_reg.op == sdue_pkg::OP_COUNT)
                    begin
                        n_reg <= it_reg.count_value;
                    end
                    else if (it_reg.op == sdue_pkg::OP_PROCESS)
                    begin
                        if (it_reg.kind == sdue_pkg::KIND_INSERT && ins_reg && rd_a != rd_b)
                        begin
                            n_reg <= n_reg + 13'd1;
                        end
                        else if (it_reg.kind == sdue_pkg::KIND_REMOVE && rem_ok_reg
                                 && n_reg != 13'd0)
                        begin
                            n_reg <= n_reg - 13'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // restoring divide of the bond cell by ly, one bit a cycle, then mapping, acceptance tests and result
    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                it_reg  <= q_item;
                lx_reg  <= lx_c;
                ly_reg  <= ly_c;
                m_reg   <= m_c;
                rem_reg <= 8'd0;
                quo_reg <= 8'd0;
            end
            ST_DIV:
            begin
                if (rem_try >= 9'(ly_reg))
                begin
                    rem_reg <= 8'(rem_try - 9'(ly_reg));
                    quo_reg <= {quo_reg[6:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_try[7:0];
                    quo_reg <= {quo_reg[6:0], 1'b0};
                end
            end
            ST_ADDR:
            begin
                s0_reg  <= SW'(a0);
                s1_reg  <= SW'(a1);
                bok_reg <= 10'(it_reg.bond) < nb;
                lhs_reg <= 40'(it_reg.random_fraction) * 40'(m_reg - n_reg);
            end
            ST_READ:
            begin
                prod_reg <= 40'(it_reg.random_fraction) * 40'(insert_weight);
                ins_reg  <= bok_reg && (n_reg < m_reg)
                            && (lhs_reg < {8'd0, insert_weight, 8'd0});
            end
            ST_MUL:
            begin
                rem_ok_reg <= (n_reg <= m_reg)
                              && (prod_reg < (40'(m_reg - n_reg + 13'd1) << 24));
            end
            ST_DEC:
            begin
                res_code_reg <= it_reg.entry_code;
                if (it_reg.op == sdue_pkg::OP_PROCESS)
                begin
                    if (it_reg.kind == sdue_pkg::KIND_INSERT && ins_reg && rd_a != rd_b)
                    begin
                        res_code_reg <= 11'({it_reg.bond, 1'b0});
                    end
                    else if (it_reg.kind == sdue_pkg::KIND_REMOVE && rem_ok_reg)
                    begin
                        res_code_reg <= -11'sd1;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || !out_stall)
                begin
                    out_code_reg  <= res_code_reg;
                    out_count_reg <= n_reg;
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// ===== rtl/sse_diagonal_update_engine.sv =====
// SSE diagonal update engine, top level: config registers, front, back.
// Depends on sdue_pkg, sdue_front, sdue_back.
//
// Input channel: in_valid/in_stall carry one word (op and fields); output
// channel: out_valid/out_stall carry new_entry_code and operator_count,
// one result word per input word, in order.
// Config: cfg_valid/cfg_ready with cfg_index (0 lattice_x, 1 lattice_y,
// 2 string_length, 3 insert_weight) and cfg_data; write only when idle.
// The back end takes a new word only once done with the last: bit-serial
// divide of the bond cell by the lattice height, mapping, spin RAM read,
// acceptance compares and, for an off-diagonal entry, the second flip write.
// A two-word queue lets the input side be taken while the back end works.
// Reset clears the operator count and config to defaults; spin RAM holds
// garbage until written. When out_stall is high the result word holds; the
// back end finishes the next word and waits. Input accepts until the queue
// fills.
`default_nettype none
module sse_diagonal_update_engine #(
    parameter int MAX_SITES = sdue_pkg::MAX_SITES,
    parameter int MAX_LEN   = sdue_pkg::MAX_LEN
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        op,
    input  wire logic signed [10:0] entry_code,
    input  wire logic [8:0]        random_bond,
    input  wire logic [15:0]       random_fraction,
    input  wire logic [7:0]        site_index,
    input  wire logic              spin_value,
    input  wire logic [12:0]       count_value,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic signed [10:0]     new_entry_code,
    output logic [12:0]            operator_count,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [23:0]       cfg_data
);
    logic [4:0]  lx_reg, ly_reg;
    logic [12:0] len_reg;
    logic [23:0] w_reg;
    sdue_pkg::item_t in_item, q_item;
    logic q_valid, q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lx_reg  <= 5'd4;
            ly_reg  <= 5'd4;
            len_reg <= 13'd10;
            w_reg   <= 24'd20480;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sdue_pkg::REG_LX:     lx_reg  <= cfg_data[4:0];
                sdue_pkg::REG_LY:     ly_reg  <= cfg_data[4:0];
                sdue_pkg::REG_LEN:    len_reg <= cfg_data[12:0];
                sdue_pkg::REG_WEIGHT: w_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        in_item.op              = op;
        in_item.kind            = sdue_pkg::KIND_NONE;
        in_item.entry_code      = entry_code;
        in_item.bond            = random_bond;
        in_item.random_fraction = random_fraction;
        in_item.site_index      = site_index;
        in_item.spin_value      = spin_value;
        in_item.count_value     = count_value;
    end

    sdue_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    sdue_back #(.MAX_SITES(MAX_SITES), .MAX_LEN(MAX_LEN)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_item         (q_item),
        .lattice_x      (lx_reg),
        .lattice_y      (ly_reg),
        .string_length  (len_reg),
        .insert_weight  (w_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .new_entry_code (new_entry_code),
        .operator_count (operator_count)
    );
endmodule
`default_nettype wire

// ===== rtl/sdue_checker.sv =====
// Port-level checks for the SSE diagonal update engine, bound to the top.
// Depends on sse_diagonal_update_engine ports only.
`default_nettype none
module sdue_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic signed [10:0] new_entry_code,
    input wire logic [12:0]       operator_count
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_entry_code)
        && $stable(operator_count))
        else $error("result word changed while stalled");

    a_rst_out: assert property (@(posedge clk)
        !rst_n |=> !out_valid || !$past(!rst_n))
        else $error("result after reset");

    a_stall_inp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("queue filled with no input");
endmodule

bind sse_diagonal_update_engine sdue_checker u_sdue_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_entry_code (new_entry_code),
    .operator_count (operator_count)
);
`default_nettype wire
